// ===== src/rar_pkg.sv =====
// Shared constants, command codes and unit status type for the rational reducer.
`default_nettype none

package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  // cross-product sum plus headroom for the magnitude of the most negative sum
  localparam int INT_W         = PROD_W + 2;
  localparam int CNT_W         = $clog2(INT_W + 1);
  localparam int RES_W         = 34;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== src/rational_arith_reduce.sv =====
// Top level: rational add/sub/mul/div with GCD reduction, sequenced over shared units.
//
// Input channel (in_valid/in_ready): command plus two signed fractions
// a_num/a_den and b_num/b_den. Output channel (out_valid/out_ready): the
// reduced res_num/res_den and status (1 when the result denominator is zero,
// then both parts read 0). A zero numerator yields 0/1. Signs are kept as the
// cross products give them, so res_den may be negative.
// One item is in flight at a time; in_ready is high only while the sequencer
// idles. An item forms two products on the single shared multiplier (three for
// add and subtract), then forms and tests the fraction, runs the binary GCD
// (one shift or subtract a cycle) and two restoring divisions of 34 quotient
// bits each on one shared divider. Zero cases skip GCD and division.
// The result sits in an output register; a new item is accepted while it waits,
// and the sequencer holds in its final step until out_ready frees that register.
// Synchronous reset returns the sequencer to idle and drops out_valid.
`default_nettype none

module rational_arith_reduce (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               command,
  input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] a_num,
  input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] a_den,
  input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] b_num,
  input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] b_den,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [rar_pkg::RES_W-1:0]         res_num,
  output logic signed [rar_pkg::RES_W-1:0]         res_den,
  output logic                                     status
);
  import rar_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL0  = 10'b0000000010,
    S_MUL1  = 10'b0000000100,
    S_MUL2  = 10'b0000001000,
    S_FORM  = 10'b0000010000,
    S_CHECK = 10'b0000100000,
    S_GCD   = 10'b0001000000,
    S_DIVN  = 10'b0010000000,
    S_DIVD  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  // operand registers
  cmd_t                            cmd_q;
  logic signed [OPERAND_WIDTH-1:0] an_q;
  logic signed [OPERAND_WIDTH-1:0] ad_q;
  logic signed [OPERAND_WIDTH-1:0] bn_q;
  logic signed [OPERAND_WIDTH-1:0] bd_q;

  // shared multiplier and its product registers
  logic signed [OPERAND_WIDTH-1:0] mul_x;
  logic signed [OPERAND_WIDTH-1:0] mul_y;
  logic signed [PROD_W-1:0]        prod;
  logic signed [PROD_W-1:0]        p0;
  logic signed [PROD_W-1:0]        p1;
  logic signed [PROD_W-1:0]        p2;

  // unreduced fraction
  logic signed [INT_W-1:0] num_q;
  logic signed [INT_W-1:0] den_q;
  logic [INT_W-1:0]        mag_n_c;
  logic [INT_W-1:0]        mag_d_c;
  logic [INT_W-1:0]        mag_n;
  logic [INT_W-1:0]        mag_d;
  logic                    neg_n;
  logic                    neg_d;

  // reduced result before it reaches the output register
  logic signed [RES_W-1:0] rn;
  logic signed [RES_W-1:0] rd;
  logic                    st;

  // shared units
  logic             gcd_start;
  logic [INT_W-1:0] gcd_g;
  unit_stat_t       gcd_stat;
  logic             div_start;
  logic [INT_W-1:0] div_dividend;
  logic [INT_W-1:0] div_q;
  unit_stat_t       div_stat;
  logic             neg_sel;
  logic [INT_W-1:0] q_signed;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Multiplier operand select: first product, cross product, denominator.
  always_comb begin
    mul_x = an_q;
    mul_y = bd_q;
    case (state)
      S_MUL0: begin
        mul_x = an_q;
        mul_y = (cmd_q == CMD_MUL) ? bn_q : bd_q;
      end
      S_MUL1: begin
        mul_x = bn_q;
        mul_y = ad_q;
      end
      S_MUL2: begin
        mul_x = ad_q;
        mul_y = (cmd_q == CMD_DIV) ? bn_q : bd_q;
      end
      default: begin
        mul_x = an_q;
        mul_y = bd_q;
      end
    endcase
  end

  assign prod = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign mag_n_c = num_q[INT_W-1] ? (INT_W'(0) - num_q) : num_q;
  assign mag_d_c = den_q[INT_W-1] ? (INT_W'(0) - den_q) : den_q;

  // Start the GCD only for a nonzero fraction; zero cases finish directly.
  assign gcd_start = (state == S_CHECK) && (num_q != '0) && (den_q != '0);

  // Divide numerator first, then denominator, by the GCD.
  assign div_start    = ((state == S_GCD) && gcd_stat.done) ||
                        ((state == S_DIVN) && div_stat.done);
  assign div_dividend = (state == S_GCD) ? mag_n : mag_d;

  // Restore the computed sign on the quotient.
  assign neg_sel  = (state == S_DIVN) ? neg_n : neg_d;
  assign q_signed = neg_sel ? (INT_W'(0) - div_q) : div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd_t'(command);
            an_q  <= a_num;
            ad_q  <= a_den;
            bn_q  <= b_num;
            bd_q  <= b_den;
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          p0 <= prod;
          // the second cross product is needed only for add and subtract
          if ((cmd_q == CMD_ADD) || (cmd_q == CMD_SUB)) begin
            state <= S_MUL1;
          end else begin
            state <= S_MUL2;
          end
        end
        S_MUL1: begin
          p1    <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= prod;
          state <= S_FORM;
        end
        S_FORM: begin
          case (cmd_q)
            CMD_ADD: num_q <= INT_W'(p0) + INT_W'(p1);
            CMD_SUB: num_q <= INT_W'(p0) - INT_W'(p1);
            default: num_q <= INT_W'(p0);
          endcase
          den_q <= INT_W'(p2);
          state <= S_CHECK;
        end
        S_CHECK: begin
          mag_n <= mag_n_c;
          mag_d <= mag_d_c;
          neg_n <= num_q[INT_W-1];
          neg_d <= den_q[INT_W-1];
          if (den_q == '0) begin
            // zero denominator: flag it and drop both parts
            rn    <= '0;
            rd    <= '0;
            st    <= 1'b1;
            state <= S_DONE;
          end else if (num_q == '0) begin
            rn    <= '0;
            rd    <= RES_W'(1);
            st    <= 1'b0;
            state <= S_DONE;
          end else begin
            st    <= 1'b0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_stat.done) begin
            state <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_stat.done) begin
            rn    <= RES_W'($signed(q_signed));
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_stat.done) begin
            rd    <= RES_W'($signed(q_signed));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            res_num   <= rn;
            res_den   <= rd;
            status    <= st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rar_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (mag_n_c),
    .b     (mag_d_c),
    .g     (gcd_g),
    .stat  (gcd_stat)
  );

  rar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .quotient (div_q),
    .stat     (div_stat)
  );

endmodule

`default_nettype wire

// ===== src/rar_gcd.sv =====
// Iterative binary GCD of two nonzero magnitudes, one shift or subtract per cycle.
`default_nettype none

module rar_gcd (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rar_pkg::INT_W-1:0] a,
  input  logic [rar_pkg::INT_W-1:0] b,
  output logic [rar_pkg::INT_W-1:0] g,
  output rar_pkg::unit_stat_t       stat
);
  import rar_pkg::*;

  logic [INT_W-1:0] u;
  logic [INT_W-1:0] v;
  logic [CNT_W-1:0] k;
  logic             active;
  logic             done;
  logic             lt;
  logic [INT_W-1:0] diff;

  // odd/odd step: subtract the smaller from the larger
  assign lt   = (u < v);
  assign diff = lt ? (v - u) : (u - v);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        u      <= a;
        v      <= b;
        k      <= '0;
        active <= 1'b1;
      end else if (active) begin
        if (u == '0) begin
          g      <= v << k;
          active <= 1'b0;
          done   <= 1'b1;
        end else if (v == '0) begin
          g      <= u << k;
          active <= 1'b0;
          done   <= 1'b1;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + CNT_W'(1);
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (lt) begin
          v <= diff >> 1;
        end else begin
          u <= diff >> 1;
        end
      end
    end
  end

  assign stat.busy = active;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== src/rar_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module rar_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rar_pkg::INT_W-1:0] dividend,
  input  logic [rar_pkg::INT_W-1:0] divisor,
  output logic [rar_pkg::INT_W-1:0] quotient,
  output rar_pkg::unit_stat_t       stat
);
  import rar_pkg::*;

  logic [INT_W:0]   rem;
  logic [INT_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic             done;
  logic [INT_W:0]   rem_sh;
  logic [INT_W:0]   trial;

  assign rem_sh = {rem[INT_W-1:0], quotient[INT_W-1]};
  assign trial  = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
        cnt      <= CNT_W'(INT_W);
        active   <= 1'b1;
      end else if (active) begin
        if (trial[INT_W]) begin
          rem      <= rem_sh;
          quotient <= {quotient[INT_W-2:0], 1'b0};
        end else begin
          rem      <= trial;
          quotient <= {quotient[INT_W-2:0], 1'b1};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = active;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== tb/sv/rational_arith_reduce_tb.sv =====
// Self-checking testbench for the rational add/sub/mul/div reducer with GCD reduction.
`default_nettype none

module rational_arith_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rar_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int QUIET_FROM   = 950;   // last random items run with no idling
  localparam int HOLD_AT      = 250;   // random item count that triggers the long hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;   // well beyond the slowest item

  // Expected reduced fraction, at the output widths
  typedef struct packed {
    logic [RES_W-1:0] num;
    logic [RES_W-1:0] den;
    logic             stat;
  } frac_t;

  // One directed row; the expected fields are used only when known is set
  typedef struct {
    cmd_t   op;
    int     an;
    int     ad;
    int     bn;
    int     bd;
    bit     known;
    longint en;
    longint ed;
    bit     es;
  } dir_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [1:0]                      command   = CMD_ADD;
  logic signed [OPERAND_WIDTH-1:0] a_num     = '0;
  logic signed [OPERAND_WIDTH-1:0] a_den     = '0;
  logic signed [OPERAND_WIDTH-1:0] b_num     = '0;
  logic signed [OPERAND_WIDTH-1:0] b_den     = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [RES_W-1:0]         res_num;
  logic signed [RES_W-1:0]         res_den;
  logic                            status;

  frac_t pending_fracs[$];
  int    err_count = 0;
  bit    quiet     = 1'b0;   // set for the tail of the run: no idling on either side
  bit    hold_req  = 1'b0;   // sender asks the receiver for one long hold-off
  bit    hold_done = 1'b0;

  // Directed rows: special cases first, extremes, then a few plain reductions.
  dir_row_t dir_rows[] = '{
    '{CMD_ADD,      1,      2,      1,      2, 1, 1,          1,           0},
    '{CMD_SUB,      1,      2,      1,      2, 1, 0,          1,           0},
    '{CMD_MUL,      0,      5,      3,      7, 1, 0,          1,           0},
    '{CMD_DIV,      1,      2,      0,      3, 1, 0,          0,           1},
    '{CMD_ADD,      1,      0,      1,      1, 1, 0,          0,           1},
    '{CMD_MUL,      0,      0,      0,      0, 1, 0,          0,           1},
    '{CMD_DIV,      5,      7,      0,      0, 1, 0,          0,           1},
    '{CMD_MUL, -32768,      1, -32768,      1, 1, 1073741824, 1,           0},
    '{CMD_ADD, -32768, -32768, -32768, -32768, 1, 2,          1,           0},
    '{CMD_DIV,  32767,  32767,  32767,  32767, 1, 1,          1,           0},
    '{CMD_MUL,     -1,      1,      1,      1, 1, -1,         1,           0},
    '{CMD_MUL,      1,     -1,      1,      1, 1, 1,          -1,          0},
    '{CMD_DIV, -32768,      1,      1, -32768, 1, 1073741824, 1,           0},
    '{CMD_SUB, -32768, -32768,  32767,  32767, 1, 0,          1,           0},
    '{CMD_ADD,  32767,      1,  32767,      1, 1, 65534,      1,           0},
    '{CMD_ADD,      1, -32768,     -1, -32768, 1, 0,          1,           0},
    '{CMD_SUB, -32768,  32767,  32767, -32768, 0, 0,          0,           0},
    '{CMD_ADD, -32768, -32768, -32768,  32767, 0, 0,          0,           0},
    '{CMD_ADD,      3,      4,      5,      6, 0, 0,          0,           0},
    '{CMD_SUB,      7,     -9,      2,      3, 0, 0,          0,           0},
    '{CMD_MUL,     12,     35,     14,    -18, 0, 0,          0,           0},
    '{CMD_DIV,     -6,     25,    -10,     15, 0, 0,          0,           0}
  };

  rational_arith_reduce u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Cross-multiply, then reduce both parts by the GCD of their magnitudes.
  // Signs stay as the products give them; zero cases short-circuit.
  function automatic frac_t reduce_fraction(input cmd_t op,
                                            input logic signed [OPERAND_WIDTH-1:0] an,
                                            input logic signed [OPERAND_WIDTH-1:0] ad,
                                            input logic signed [OPERAND_WIDTH-1:0] bn,
                                            input logic signed [OPERAND_WIDTH-1:0] bd);
    longint          xn, xd, yn, yd, top, bot, q_top, q_bot;
    longint unsigned m_top, m_bot, g, h, r;
    frac_t           f;
    xn = an;
    xd = ad;
    yn = bn;
    yd = bd;
    case (op)
      CMD_ADD: begin
        top = xn * yd + yn * xd;
        bot = xd * yd;
      end
      CMD_SUB: begin
        top = xn * yd - yn * xd;
        bot = xd * yd;
      end
      CMD_MUL: begin
        top = xn * yn;
        bot = xd * yd;
      end
      default: begin
        top = xn * yd;
        bot = xd * yn;
      end
    endcase
    m_top = (top < 0) ? -top : top;
    m_bot = (bot < 0) ? -bot : bot;
    if (m_bot == 0) begin
      f = '{num: '0, den: '0, stat: 1'b1};
    end else if (m_top == 0) begin
      f = '{num: '0, den: 1, stat: 1'b0};
    end else begin
      g = m_top;
      h = m_bot;
      while (h != 0) begin
        r = g % h;
        g = h;
        h = r;
      end
      q_top = m_top / g;
      q_bot = m_bot / g;
      if (top < 0) q_top = -q_top;
      if (bot < 0) q_bot = -q_bot;
      f.num  = q_top[RES_W-1:0];
      f.den  = q_bot[RES_W-1:0];
      f.stat = 1'b0;
    end
    return f;
  endfunction

  // Offer one item at the current falling edge and hold it until accepted;
  // the expectation is queued at the accepting edge. Returns at a falling edge
  // with valid still high, so the caller decides whether to idle.
  task automatic offer_item(input cmd_t op,
                            input logic signed [OPERAND_WIDTH-1:0] an,
                            input logic signed [OPERAND_WIDTH-1:0] ad,
                            input logic signed [OPERAND_WIDTH-1:0] bn,
                            input logic signed [OPERAND_WIDTH-1:0] bd,
                            input frac_t want);
    in_valid <= 1'b1;
    command  <= op;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    do @(posedge clk); while (!in_ready);
    pending_fracs.push_back(want);
    @(negedge clk);
  endtask

  // Drop valid for a random burst now and then, unless the tail is running.
  task automatic maybe_idle_sender();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Pick one operand value by flavor: full range, small, extremes or zero.
  function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand(input int flavor);
    logic signed [OPERAND_WIDTH-1:0] v;
    case (flavor)
      0:       v = OPERAND_WIDTH'($urandom);
      1:       v = OPERAND_WIDTH'($urandom_range(0, 128) - 64);
      2: begin
        case ($urandom_range(0, 4))
          0:       v = OPERAND_WIDTH'(-32768);
          1:       v = OPERAND_WIDTH'(-1);
          2:       v = '0;
          3:       v = OPERAND_WIDTH'(1);
          default: v = OPERAND_WIDTH'(32767);
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    frac_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_fracs.size() == 0) begin
        flag_error($sformatf("unexpected result %0d/%0d status %0b",
                             res_num, res_den, status));
      end else begin
        want = pending_fracs.pop_front();
        if (res_num !== want.num)
          flag_error($sformatf("res_num got %0d want %0d", res_num, $signed(want.num)));
        if (res_den !== want.den)
          flag_error($sformatf("res_den got %0d want %0d", res_den, $signed(want.den)));
        if (status !== want.stat)
          flag_error($sformatf("status got %0b want %0b", status, want.stat));
      end
    end
  end

  // Main sequence: reset, directed table, random items, drain, verdict.
  initial begin
    cmd_t                            op;
    logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
    frac_t                           want;
    int                              kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: typed expectations where obvious, predictor elsewhere.
    foreach (dir_rows[i]) begin
      op = dir_rows[i].op;
      an = OPERAND_WIDTH'(dir_rows[i].an);
      ad = OPERAND_WIDTH'(dir_rows[i].ad);
      bn = OPERAND_WIDTH'(dir_rows[i].bn);
      bd = OPERAND_WIDTH'(dir_rows[i].bd);
      if (dir_rows[i].known)
        want = '{num: dir_rows[i].en[RES_W-1:0], den: dir_rows[i].ed[RES_W-1:0],
                 stat: dir_rows[i].es};
      else
        want = reduce_fraction(op, an, ad, bn, bd);
      offer_item(op, an, ad, bn, bd, want);
      maybe_idle_sender();
    end

    // Random part: mostly full-range operands, with small values for deep
    // reductions, extremes, and forced zero numerators or denominators.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == QUIET_FROM) quiet = 1'b1;
      op   = cmd_t'($urandom_range(0, 3));
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        an = pick_operand(0); ad = pick_operand(0);
        bn = pick_operand(0); bd = pick_operand(0);
      end else if (kind <= 6) begin
        an = pick_operand(1); ad = pick_operand(1);
        bn = pick_operand(1); bd = pick_operand(1);
      end else if (kind == 7) begin
        an = pick_operand(2); ad = pick_operand(2);
        bn = pick_operand(2); bd = pick_operand(2);
      end else if (kind == 8) begin
        // zero numerator: clear the operand(s) feeding the numerator
        an = pick_operand(0); ad = pick_operand(1);
        bn = pick_operand(0); bd = pick_operand(1);
        if (op == CMD_MUL || op == CMD_DIV) begin
          an = '0;
        end else begin
          an = '0;
          bn = '0;
        end
      end else begin
        // zero denominator: clear one factor of the result denominator
        an = pick_operand(0); ad = pick_operand(0);
        bn = pick_operand(0); bd = pick_operand(0);
        if ($urandom_range(0, 1) == 0) ad = '0;
        else if (op == CMD_DIV) bn = '0;
        else bd = '0;
      end
      offer_item(op, an, ad, bn, bd, reduce_fraction(op, an, ad, bn, bd));
      maybe_idle_sender();
    end
    in_valid <= 1'b0;

    // Drain: wait for every expectation, then watch for stray results.
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("rational_arith_reduce_tb: done, clean");
    else
      $display("rational_arith_reduce_tb: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("rational_arith_reduce_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
